// ===== rtl/i2c_master_transfer_sequencer_defines.svh =====
// ----------------------------------------------------------------------------
// i2c master transfer sequencer assertion macros
// shared check forms, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_DEFINES_SVH

// same-cycle implication
`define I2CMTS_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("i2c sequencer check failed");

// next-cycle implication
`define I2CMTS_ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("i2c sequencer check failed");

`endif

// ===== rtl/i2cmts_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cmts_pkg
// types, codes and helpers shared by the i2c master transfer sequencer
// ----------------------------------------------------------------------------
package i2cmts_pkg;

    // default transfer length limit
    localparam int MAX_TRANSFER_BYTES = 255;

    // request opcodes
    localparam logic OP_START = 1'b0;
    localparam logic OP_EVENT = 1'b1;

    // ack control codes
    localparam logic [1:0] ACK_NONE  = 2'd0;
    localparam logic [1:0] ACK_SET   = 2'd1;
    localparam logic [1:0] ACK_CLEAR = 2'd2;

    // interrupt control codes
    localparam logic [1:0] IRQ_NONE    = 2'd0;
    localparam logic [1:0] IRQ_ON      = 2'd1;
    localparam logic [1:0] IRQ_DISABLE = 2'd2;

    // reported state codes
    localparam logic [2:0] CODE_IDLE        = 3'd0;
    localparam logic [2:0] CODE_BEGIN       = 3'd1;
    localparam logic [2:0] CODE_START_SENT  = 3'd2;
    localparam logic [2:0] CODE_IN_PROGRESS = 3'd3;
    localparam logic [2:0] CODE_DATA_SENT   = 3'd4;
    localparam logic [2:0] CODE_ERROR       = 3'd5;

    // sequencer phase, one-hot
    typedef enum logic [5:0] {
        PH_IDLE        = 6'b000001,
        PH_BEGIN       = 6'b000010,
        PH_START_SENT  = 6'b000100,
        PH_IN_PROGRESS = 6'b001000,
        PH_DATA_SENT   = 6'b010000,
        PH_ERROR       = 6'b100000
    } phase_t;

    // one input request
    typedef struct packed {
        logic       opcode;
        logic [6:0] target_address;
        logic       direction;
        logic [7:0] byte_count;
        logic       flag_start_sent;
        logic       flag_address_done;
        logic       flag_tx_empty;
        logic       flag_rx_full;
        logic [7:0] received_byte;
        logic [7:0] next_tx_byte;
    } item_t;

    // one result
    typedef struct packed {
        logic       start_accepted;
        logic       data_write_valid;
        logic [7:0] data_write_value;
        logic       read_valid;
        logic [7:0] read_value;
        logic       request_start;
        logic       request_stop;
        logic [1:0] ack_action;
        logic [1:0] irq_action;
        logic [2:0] state_now;
    } result_t;

    // phase to reported code
    function automatic logic [2:0] phase_code(input phase_t ph);
        logic [2:0] code;
        case (ph)
            PH_IDLE:        code = CODE_IDLE;
            PH_BEGIN:       code = CODE_BEGIN;
            PH_START_SENT:  code = CODE_START_SENT;
            PH_IN_PROGRESS: code = CODE_IN_PROGRESS;
            PH_DATA_SENT:   code = CODE_DATA_SENT;
            default:        code = CODE_ERROR;
        endcase
        return code;
    endfunction

endpackage

// ===== rtl/i2c_master_transfer_sequencer.sv =====
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer
// event-driven sequencer of an i2c master: start requests and controller
// events in, data register, ack, start/stop and interrupt actions out
//
//   channel  handshake            payload
//   in       in_valid / in_stall  opcode .. next_tx_byte
//   out      out_valid/ out_stall start_accepted .. state_now
//
// one request per cycle while out_stall is low; each request leaves one result,
// registered twice (input register, then step logic into the result register)
// the transfer state updates as a request moves from input to result register
// a stalled output holds the result; the input register still takes one more
// request, after which in_stall follows out_stall
// reset is asynchronous and puts the sequencer in idle with no transfer set
// ----------------------------------------------------------------------------
module i2c_master_transfer_sequencer #(
    parameter int MAX_TRANSFER_BYTES = i2cmts_pkg::MAX_TRANSFER_BYTES
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       opcode,
    input  logic [6:0] target_address,
    input  logic       direction,
    input  logic [7:0] byte_count,
    input  logic       flag_start_sent,
    input  logic       flag_address_done,
    input  logic       flag_tx_empty,
    input  logic       flag_rx_full,
    input  logic [7:0] received_byte,
    input  logic [7:0] next_tx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       start_accepted,
    output logic       data_write_valid,
    output logic [7:0] data_write_value,
    output logic       read_valid,
    output logic [7:0] read_value,
    output logic       request_start,
    output logic       request_stop,
    output logic [1:0] ack_action,
    output logic [1:0] irq_action,
    output logic [2:0] state_now
);

    logic                in_valid_reg, in_valid_next;
    i2cmts_pkg::item_t   item_reg;
    logic                res_valid_reg, res_valid_next;
    i2cmts_pkg::result_t res_reg;
    i2cmts_pkg::result_t step_result;
    logic                accept;
    logic                advance;

    // handshake
    assign advance  = in_valid_reg && (!res_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (advance)
            res_valid_next = 1'b1;
        else if (!out_stall)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // input request register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.opcode            <= opcode;
            item_reg.target_address    <= target_address;
            item_reg.direction         <= direction;
            item_reg.byte_count        <= byte_count;
            item_reg.flag_start_sent   <= flag_start_sent;
            item_reg.flag_address_done <= flag_address_done;
            item_reg.flag_tx_empty     <= flag_tx_empty;
            item_reg.flag_rx_full      <= flag_rx_full;
            item_reg.received_byte     <= received_byte;
            item_reg.next_tx_byte      <= next_tx_byte;
        end
    end

    // sequencer state and step logic
    i2cmts_core #(
        .MAX_TRANSFER_BYTES (MAX_TRANSFER_BYTES)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (item_reg),
        .result  (step_result)
    );

    // result register
    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= step_result;
    end

    assign out_valid        = res_valid_reg;
    assign start_accepted   = res_reg.start_accepted;
    assign data_write_valid = res_reg.data_write_valid;
    assign data_write_value = res_reg.data_write_value;
    assign read_valid       = res_reg.read_valid;
    assign read_value       = res_reg.read_value;
    assign request_start    = res_reg.request_start;
    assign request_stop     = res_reg.request_stop;
    assign ack_action       = res_reg.ack_action;
    assign irq_action       = res_reg.irq_action;
    assign state_now        = res_reg.state_now;

endmodule

// ===== rtl/i2cmts_core.sv =====
// ----------------------------------------------------------------------------
// i2cmts_core
// transfer state and the single-pass step logic for one request
// ----------------------------------------------------------------------------
`include "i2c_master_transfer_sequencer_defines.svh"

module i2cmts_core #(
    parameter int MAX_TRANSFER_BYTES = i2cmts_pkg::MAX_TRANSFER_BYTES
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step_en,
    input  i2cmts_pkg::item_t   item,
    output i2cmts_pkg::result_t result
);

    localparam int CNT_W = $clog2(MAX_TRANSFER_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TRANSFER_BYTES);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    i2cmts_pkg::phase_t phase_reg, phase_next;
    logic [6:0]         addr_reg, addr_next;
    logic               dir_reg, dir_next;
    logic [CNT_W-1:0]   total_reg, total_next;
    logic [CNT_W-1:0]   done_reg, done_next;

    logic [CNT_W-1:0]   remain;
    logic               data_phase;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= i2cmts_pkg::PH_IDLE;
            addr_reg  <= '0;
            dir_reg   <= 1'b0;
            total_reg <= '0;
            done_reg  <= '0;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            addr_reg  <= addr_next;
            dir_reg   <= dir_next;
            total_reg <= total_next;
            done_reg  <= done_next;
        end
    end

    assign remain     = total_reg - done_reg;
    assign data_phase = (item.opcode == i2cmts_pkg::OP_EVENT)
                        && ((phase_reg == i2cmts_pkg::PH_START_SENT)
                            || (phase_reg == i2cmts_pkg::PH_IN_PROGRESS));

    // next state and result for the request at hand
    always_comb
    begin
        phase_next = phase_reg;
        addr_next  = addr_reg;
        dir_next   = dir_reg;
        total_next = total_reg;
        done_next  = done_reg;
        result     = '0;

        if (item.opcode == i2cmts_pkg::OP_START)
        begin
            // start is taken only while idle
            if (phase_reg == i2cmts_pkg::PH_IDLE)
            begin
                if (32'(item.byte_count) > 32'(MAX_TRANSFER_BYTES))
                    total_next = CNT_MAX;
                else
                    total_next = CNT_W'(item.byte_count);
                addr_next             = item.target_address;
                dir_next              = item.direction;
                done_next             = '0;
                phase_next            = i2cmts_pkg::PH_BEGIN;
                result.start_accepted = 1'b1;
                result.request_start  = 1'b1;
                result.irq_action     = i2cmts_pkg::IRQ_ON;
            end
        end
        else
        begin
            case (phase_reg)
                i2cmts_pkg::PH_BEGIN:
                begin
                    // send address byte once start is on the bus
                    if (item.flag_start_sent)
                    begin
                        if (dir_reg)
                            result.ack_action = i2cmts_pkg::ACK_SET;
                        result.data_write_valid = 1'b1;
                        result.data_write_value = {addr_reg, dir_reg};
                        phase_next              = i2cmts_pkg::PH_START_SENT;
                    end
                end
                i2cmts_pkg::PH_START_SENT:
                begin
                    if (item.flag_address_done)
                        phase_next = i2cmts_pkg::PH_IN_PROGRESS;
                end
                i2cmts_pkg::PH_IN_PROGRESS:
                begin
                    phase_next = phase_reg;
                end
                i2cmts_pkg::PH_DATA_SENT:
                begin
                    phase_next          = i2cmts_pkg::PH_IDLE;
                    result.request_stop = 1'b1;
                    result.irq_action   = i2cmts_pkg::IRQ_DISABLE;
                end
                default:
                begin
                    phase_next = i2cmts_pkg::PH_ERROR;
                end
            endcase

            // data byte step, start_sent falls through into it
            if (data_phase && (done_reg < total_reg))
            begin
                if (!dir_reg && item.flag_tx_empty)
                begin
                    result.data_write_valid = 1'b1;
                    result.data_write_value = item.next_tx_byte;
                    done_next               = done_reg + CNT_ONE;
                    if (remain == CNT_ONE)
                        phase_next = i2cmts_pkg::PH_DATA_SENT;
                end
                else if (dir_reg && item.flag_rx_full)
                begin
                    // last read byte: nack and stop
                    if (remain == CNT_ONE)
                    begin
                        result.ack_action   = i2cmts_pkg::ACK_CLEAR;
                        result.request_stop = 1'b1;
                        result.irq_action   = i2cmts_pkg::IRQ_DISABLE;
                        phase_next          = i2cmts_pkg::PH_IDLE;
                    end
                    result.read_valid = 1'b1;
                    result.read_value = item.received_byte;
                    done_next         = done_reg + CNT_ONE;
                end
            end
        end

        result.state_now = i2cmts_pkg::phase_code(phase_next);
    end

    // checks
    `I2CMTS_ASSERT_IMP(a_done_le_total, 1'b1, done_reg <= total_reg)
    `I2CMTS_ASSERT_NXT(a_start_to_begin, step_en && result.start_accepted,
        phase_reg == i2cmts_pkg::PH_BEGIN)
    `I2CMTS_ASSERT_NXT(a_read_stop_idle, step_en && result.read_valid && result.request_stop,
        phase_reg == i2cmts_pkg::PH_IDLE)
    `I2CMTS_ASSERT_NXT(a_error_sticky, phase_reg == i2cmts_pkg::PH_ERROR,
        phase_reg == i2cmts_pkg::PH_ERROR)

endmodule
